>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/crc32rc_pkg.sv
// Shared types, constants and status codes for the CRC-32 record checker.
// No dependencies; imported by every module of the block.
package crc32rc_pkg;

	localparam int CRC_BYTES    = 4;
	localparam int LENGTH_BYTES = 2;
	localparam int HEADER_BYTES = CRC_BYTES + LENGTH_BYTES;

	localparam int CRC_LANE_W = $clog2(CRC_BYTES);
	localparam int LEN_LANE_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

	localparam logic [31:0] POLY_RESET   = 32'h82608EDB;
	localparam logic [15:0] BUFLEN_RESET = 16'd256;

	// Configuration register indexes.
	localparam logic CFG_CRC_POLYNOMIAL = 1'b0;
	localparam logic CFG_BUFFER_LENGTH  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_MATCH        = 3'd0;
	localparam logic [2:0] ST_MISMATCH     = 3'd1;
	localparam logic [2:0] ST_SHORT_BUFFER = 3'd2;
	localparam logic [2:0] ST_TOO_LONG     = 3'd3;
	localparam logic [2:0] ST_BELOW_CRC    = 3'd4;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] computed_crc;
		logic [31:0] stored_crc;
		logic [7:0]  record_length;
	} out_t;

	// Decision of the record tracker for the beat it is looking at.
	typedef struct packed {
		logic hit;
		out_t data;
	} verdict_t;

endpackage

>>> hdl/crc32_record_checker_core.sv
// CRC-32 record checker, top level: configuration registers, input register,
// record tracker and result register. Depends on crc32rc_pkg and crc32rc_tracker.
//
// The block checks a stored record streamed one byte per beat from offset 0.
// A beat with first_byte set starts a new record (and drops any record in
// progress). Bytes 0..3 carry the stored CRC little-endian, bytes 4..5 a
// little-endian length field whose low eight bits give the record length L.
// An LSB-first CRC-32 (initial value zero, no final xor, polynomial taken from
// the crc_polynomial register) runs over bytes 4..L-1. One result beat comes
// out per record: on the first byte if buffer_length is below the six-byte
// header, on the last header byte if the record is longer than buffer_length
// or L is below four, and otherwise on byte max(L, 6) - 1 with a match or
// mismatch status. Bytes that arrive with no record open are dropped silently.
// Throughput is one byte per clock cycle: the input register feeds an
// unrolled eight-bit CRC update that is purely combinational, so a new byte
// is taken every cycle unless a result beat is held by result_stall. The
// last byte of a record is captured in the input register, and its verdict
// is then loaded into the result register as soon as that register can take
// it. The result register lets the next bytes keep flowing while a finished
// result waits to be taken. Configuration writes take effect on the next
// cycle and are meant to be made while no record is in flight.
module crc32_record_checker_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  crc32rc_pkg::in_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output crc32rc_pkg::out_t  result,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);
	import crc32rc_pkg::*;

	logic [31:0] poly_q;
	logic [15:0] buflen_q;

	in_t      item_s1;
	logic     valid_s1;
	verdict_t verdict;
	logic     out_ready;
	logic     fire_s1;
	out_t     result_q;
	logic     result_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= POLY_RESET;
			buflen_q <= BUFLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CRC_POLYNOMIAL: poly_q   <= cfg_data;
				CFG_BUFFER_LENGTH:  buflen_q <= cfg_data[15:0];
				default:            poly_q   <= poly_q;
			endcase
		end
	end

	// The result register can take a new beat when it is empty or being drained.
	assign out_ready = !result_valid_q || !result_stall;

	// A byte in the input register moves on unless it makes a result that has
	// nowhere to go yet.
	assign fire_s1    = valid_s1 && (!verdict.hit || out_ready);
	assign item_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	crc32rc_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (item_s1),
		.beat_valid    (valid_s1),
		.advance       (fire_s1),
		.poly          (poly_q),
		.buffer_length (buflen_q),
		.verdict       (verdict)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ready) begin
			result_valid_q <= verdict.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && verdict.hit) begin
			result_q <= verdict.data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> hdl/crc32rc_byte_update.sv
// Eight-bit LSB-first CRC-32 update with a programmable reflected polynomial.
// Imports crc32rc_pkg, though it uses nothing from it; purely combinational.
module crc32rc_byte_update (
	input  logic [31:0] crc,
	input  logic [7:0]  data,
	input  logic [31:0] poly,
	output logic [31:0] crc_next
);
	import crc32rc_pkg::*;

	always_comb begin
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int n = 0; n < 8; n++) begin
			fb = c[0] ^ data[n];
			c  = {1'b0, c[31:1]} ^ (fb ? poly : 32'h0);
		end
		crc_next = c;
	end

endmodule

>>> hdl/crc32rc_tracker.sv
// Record state (CRC, header fields, byte position) and the per-beat verdict.
// Depends on crc32rc_pkg and crc32rc_byte_update.
module crc32rc_tracker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crc32rc_pkg::in_t      beat,
	input  logic                  beat_valid,
	input  logic                  advance,
	input  logic [31:0]           poly,
	input  logic [15:0]           buffer_length,
	output crc32rc_pkg::verdict_t verdict
);
	import crc32rc_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] hcrc_q;
	logic [15:0] lenf_q;
	logic [7:0]  pos_q;
	logic        active_q;

	logic [31:0] crc0, hcrc0, hcrc1, crc1, crc_upd;
	logic [15:0] lenf0, lenf1;
	logic [7:0]  pos0, len, last;
	logic        act0, short_buf, work, crc_en, at_hdr_end, done;
	logic [CRC_LANE_W-1:0] crc_lane;
	logic [LEN_LANE_W-1:0] len_lane;
	logic [7:0]  len_off;

	crc32rc_byte_update u_upd (
		.crc      (crc0),
		.data     (beat.byte_value),
		.poly     (poly),
		.crc_next (crc_upd)
	);

	always_comb begin
		// A first byte restarts the record from a clean header.
		crc0  = beat.first_byte ? 32'h0 : crc_q;
		hcrc0 = beat.first_byte ? 32'h0 : hcrc_q;
		lenf0 = beat.first_byte ? 16'h0 : lenf_q;
		pos0  = beat.first_byte ? 8'h0 : pos_q;
		act0  = beat.first_byte | active_q;

		short_buf = beat.first_byte && (buffer_length < 16'(HEADER_BYTES));
		work      = act0 && !short_buf;

		crc_lane = pos0[CRC_LANE_W-1:0];
		len_off  = pos0 - 8'(CRC_BYTES);
		len_lane = len_off[LEN_LANE_W-1:0];

		hcrc1 = hcrc0;
		if (pos0 < 8'(CRC_BYTES)) begin
			hcrc1[8*crc_lane +: 8] = beat.byte_value;
		end
		lenf1 = lenf0;
		if (pos0 >= 8'(CRC_BYTES) && pos0 < 8'(HEADER_BYTES)) begin
			lenf1[8*len_lane +: 8] = beat.byte_value;
		end

		len    = lenf1[7:0];
		crc_en = (pos0 >= 8'(CRC_BYTES)) && (pos0 < len);
		crc1   = crc_en ? crc_upd : crc0;

		at_hdr_end = (pos0 == 8'(HEADER_BYTES - 1));
		last       = ((len > 8'(HEADER_BYTES)) ? len : 8'(HEADER_BYTES)) - 8'd1;
		done       = (pos0 >= 8'(HEADER_BYTES - 1)) && (pos0 >= last);

		verdict = '0;
		priority if (short_buf) begin
			verdict.hit         = 1'b1;
			verdict.data.status = ST_SHORT_BUFFER;
		end else if (!work) begin
			verdict.hit = 1'b0;
		end else if (at_hdr_end && (buffer_length < {8'h0, len})) begin
			verdict.hit                = 1'b1;
			verdict.data.status        = ST_TOO_LONG;
			verdict.data.stored_crc    = hcrc1;
			verdict.data.record_length = len;
		end else if (at_hdr_end && (len < 8'(CRC_BYTES))) begin
			verdict.hit                = 1'b1;
			verdict.data.status        = ST_BELOW_CRC;
			verdict.data.stored_crc    = hcrc1;
			verdict.data.record_length = len;
		end else if (done) begin
			verdict.hit                = 1'b1;
			verdict.data.status        = (crc1 == hcrc1) ? ST_MATCH : ST_MISMATCH;
			verdict.data.computed_crc  = crc1;
			verdict.data.stored_crc    = hcrc1;
			verdict.data.record_length = len;
		end else begin
			verdict.hit = 1'b0;
		end
		verdict.hit = verdict.hit & beat_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			hcrc_q   <= '0;
			lenf_q   <= '0;
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (advance) begin
			if (short_buf) begin
				active_q <= 1'b0;
			end else if (work) begin
				crc_q    <= crc1;
				hcrc_q   <= hcrc1;
				lenf_q   <= lenf1;
				pos_q    <= verdict.hit ? pos0 : pos0 + 8'd1;
				active_q <= !verdict.hit;
			end
		end
	end

endmodule

>>> hdl/crc32rc_checker.sv
// Port-level assertions for the CRC-32 record checker and their bind.
// Depends on crc32rc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crc32rc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input crc32rc_pkg::out_t result
);
	import crc32rc_pkg::*;

	logic held;
	logic short_beat;
	logic done_beat;
	logic hdr_err_beat;
	logic fields_clear;
	logic crc_equal;

	assign held         = result_valid && result_stall;
	assign short_beat   = result_valid && (result.status == ST_SHORT_BUFFER);
	assign done_beat    = result_valid &&
		((result.status == ST_MATCH) || (result.status == ST_MISMATCH));
	assign hdr_err_beat = result_valid &&
		((result.status == ST_TOO_LONG) || (result.status == ST_BELOW_CRC));
	assign fields_clear = (result.computed_crc == 32'h0) && (result.stored_crc == 32'h0) &&
		(result.record_length == 8'h0);
	assign crc_equal    = (result.computed_crc == result.stored_crc);

	// A held result beat stays put until it is taken.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, held, result_valid && $stable(result))

	// A short buffer is reported with every other field cleared.
	`ASSERT_IMPLIES(a_short_clear, clk, arst_n, short_beat, fields_clear)

	// A match status always carries equal CRCs, a mismatch unequal ones.
	`ASSERT_IMPLIES(a_match_consistent, clk, arst_n, done_beat, (result.status == ST_MATCH) == crc_equal)

	// Header errors never report a computed CRC.
	`ASSERT_IMPLIES(a_header_err_crc, clk, arst_n, hdr_err_beat, result.computed_crc == 32'h0)

	// A completed record is at least as long as the CRC field.
	`ASSERT_IMPLIES(a_len_floor, clk, arst_n, done_beat, result.record_length >= 8'(CRC_BYTES))

endmodule

bind crc32_record_checker_core crc32rc_checker u_crc32rc_checker (.*);
